FILE: rtl/rmq_pkg.sv
// Package for the rotation-matrix-to-quaternion core: beat types, widths and constants.
// Has no dependencies. The other rtl files import it.
`default_nettype none
package rmq_pkg;
  localparam int FRAC_BITS = 16;
  localparam int RAD_W = 35;                 // radicand, always below 2^34
  localparam int SQ_W  = RAD_W + FRAC_BITS;  // shifted radicand
  localparam int S_W   = (SQ_W + 1) / 2;     // root width
  localparam int NUM_W = 2 * FRAC_BITS;      // dividend 2^(2F-1)
  localparam int DIF_W = 33;                 // off-diagonal sum or difference

  typedef struct packed {
    logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } mat_t;

  typedef struct packed {
    logic signed [31:0] quat_x, quat_y, quat_z, quat_w;
    logic               bad_matrix;
  } quat_t;

  // Carried along the pipeline next to the root and divider.
  typedef struct packed {
    logic [1:0]               axis;   // 3 means the trace path
    logic                     bad;
    logic signed [DIF_W-1:0]  d0, d1, d2;  // numerators for x,y,z (or w,qj,qk)
  } side_t;

  localparam logic [1:0] AX_TRACE = 2'd3;
endpackage
`default_nettype wire

FILE: rtl/rotation_matrix_to_quaternion_core.sv
// Top level: matrix front end, root and divider pipelines, scaling multiplies, output register.
// Depends on rmq_pkg, rmq_sqrt_pipe and rmq_div_pipe.
//
//  channel   dir  handshake                payload
//  mat       in   mat_valid / mat_ready    mat_t  (m00..m22)
//  quat      out  quat_valid / quat_ready  quat_t (x,y,z,w,bad_matrix)
//
// One matrix per cycle while the output is not stalled. At FRAC_BITS 16 the path is the front
// end, the one-bit-per-stage square root (26 stages) and divider (32 stages), one multiply
// stage and the output register, with saturation ahead of it. Reset clears
// all valid bits. The whole pipeline advances together; a stall at the output holds
// every stage in place, and the output register accepts a new beat in the cycle its
// held beat leaves.
`default_nettype none
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic mat_valid,
  output logic      mat_ready,
  input  wire mat_t mat,
  output logic      quat_valid,
  input  wire logic quat_ready,
  output quat_t     quat
);
  logic en;

  // stage 1: trace, axis pick, radicand, numerators
  logic                    v1;
  logic [SQ_W-1:0]         rad1;
  side_t                   sd1;
  logic signed [33:0]      tr;
  logic [1:0]              ax;
  logic signed [RAD_W-1:0] rad;
  logic signed [31:0]      mii, mjj, mkk;
  side_t                   sdn;

  always_comb begin
    tr = 34'(mat.m00) + 34'(mat.m11) + 34'(mat.m22);
    ax = 2'd0;
    if (mat.m11 > mat.m00) ax = 2'd1;
    if (mat.m22 > ((ax == 2'd1) ? mat.m11 : mat.m00)) ax = 2'd2;
    case (ax)
      2'd0:    begin mii = mat.m00; mjj = mat.m11; mkk = mat.m22; end
      2'd1:    begin mii = mat.m11; mjj = mat.m22; mkk = mat.m00; end
      default: begin mii = mat.m22; mjj = mat.m00; mkk = mat.m11; end
    endcase
    sdn = '0;
    if (!tr[33]) begin
      rad     = RAD_W'(tr) + (RAD_W'(1) <<< FRAC_BITS);
      sdn.axis = AX_TRACE;
      sdn.d0  = DIF_W'(mat.m12) - DIF_W'(mat.m21);
      sdn.d1  = DIF_W'(mat.m20) - DIF_W'(mat.m02);
      sdn.d2  = DIF_W'(mat.m01) - DIF_W'(mat.m10);
    end else begin
      rad = RAD_W'(mii) - (RAD_W'(mjj) + RAD_W'(mkk)) + (RAD_W'(1) <<< FRAC_BITS);
      sdn.axis = ax;
      sdn.bad  = (rad <= 0);
      case (ax)
        2'd0: begin
          sdn.d0 = DIF_W'(mat.m12) - DIF_W'(mat.m21);
          sdn.d1 = DIF_W'(mat.m01) + DIF_W'(mat.m10);
          sdn.d2 = DIF_W'(mat.m02) + DIF_W'(mat.m20);
        end
        2'd1: begin
          sdn.d0 = DIF_W'(mat.m20) - DIF_W'(mat.m02);
          sdn.d1 = DIF_W'(mat.m12) + DIF_W'(mat.m21);
          sdn.d2 = DIF_W'(mat.m10) + DIF_W'(mat.m01);
        end
        default: begin
          sdn.d0 = DIF_W'(mat.m01) - DIF_W'(mat.m10);
          sdn.d1 = DIF_W'(mat.m20) + DIF_W'(mat.m02);
          sdn.d2 = DIF_W'(mat.m21) + DIF_W'(mat.m12);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= mat_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      // bad radicand replaced by 1 to keep the divider off zero
      rad1 <= sdn.bad ? SQ_W'(1) : SQ_W'({rad[RAD_W-2:0], {FRAC_BITS{1'b0}}});
      sd1  <= sdn;
    end
  end

  logic          v2;
  logic [S_W-1:0] root2;
  side_t          sd2;
  rmq_sqrt_pipe u_sqrt (
    .clk, .rst, .en, .in_valid(v1), .in_rad(rad1), .in_side(sd1),
    .out_valid(v2), .out_root(root2), .out_side(sd2)
  );

  logic             v3;
  logic [NUM_W-1:0] inv3;
  logic [S_W-1:0]   s3;
  side_t            sd3;
  rmq_div_pipe u_div (
    .clk, .rst, .en, .in_valid(v2), .in_s(root2), .in_side(sd2),
    .out_valid(v3), .out_inv(inv3), .out_s(s3), .out_side(sd3)
  );

  // multiply stage: |d| * inv, sign kept aside
  logic                v4;
  logic [DIF_W+NUM_W-1:0] p4 [3];
  logic [2:0]          neg4;
  logic [S_W-1:0]      s4;
  side_t               sd4;
  logic [DIF_W-1:0]    mag [3];
  always_comb begin
    mag[0] = sd3.d0[DIF_W-1] ? DIF_W'(-sd3.d0) : DIF_W'(sd3.d0);
    mag[1] = sd3.d1[DIF_W-1] ? DIF_W'(-sd3.d1) : DIF_W'(sd3.d1);
    mag[2] = sd3.d2[DIF_W-1] ? DIF_W'(-sd3.d2) : DIF_W'(sd3.d2);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 3; n++) p4[n] <= (DIF_W+NUM_W)'(mag[n]) * (DIF_W+NUM_W)'(inv3);
      neg4 <= {sd3.d2[DIF_W-1], sd3.d1[DIF_W-1], sd3.d0[DIF_W-1]};
      s4   <= s3;
      sd4  <= sd3;
    end
  end

  // scale, floor for negatives, saturate, place components
  logic signed [31:0] r [3];
  logic signed [31:0] half;
  quat_t qn;
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      logic [DIF_W+NUM_W-1:0] q;
      logic rem_nz;
      q      = p4[n] >> FRAC_BITS;
      rem_nz = |p4[n][FRAC_BITS-1:0];
      if (neg4[n]) begin
        q = q + (DIF_W+NUM_W)'(rem_nz);
        r[n] = (q > (DIF_W+NUM_W)'(32'h8000_0000)) ? 32'sh8000_0000 : 32'(-q);
      end else begin
        r[n] = (q > (DIF_W+NUM_W)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(q);
      end
    end
    half = 32'(s4 >> 1);
    qn = '0;
    if (sd4.bad) begin
      qn.bad_matrix = 1'b1;
    end else begin
      case (sd4.axis)
        2'd0:    begin qn.quat_x = half; qn.quat_w = r[0]; qn.quat_y = r[1]; qn.quat_z = r[2]; end
        2'd1:    begin qn.quat_y = half; qn.quat_w = r[0]; qn.quat_z = r[1]; qn.quat_x = r[2]; end
        2'd2:    begin qn.quat_z = half; qn.quat_w = r[0]; qn.quat_x = r[1]; qn.quat_y = r[2]; end
        default: begin qn.quat_w = half; qn.quat_x = r[0]; qn.quat_y = r[1]; qn.quat_z = r[2]; end
      endcase
    end
  end

  assign en        = !quat_valid || quat_ready;
  assign mat_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
    end else if (en) begin
      quat_valid <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      quat <= qn;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/rmq_sqrt_pipe.sv
// Pipelined bit-pair integer square root, one result bit per stage, with side data.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt_pipe import rmq_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [SQ_W-1:0] in_rad,
  input  wire side_t           in_side,
  output logic                 out_valid,
  output logic [S_W-1:0]       out_root,
  output side_t                out_side
);
  logic [S_W-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_W-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < S_W; g++) begin : g_st
    logic [2*S_W-1:0] rem, val, rem_i, val_i;
    logic [S_W-1:0]   root, root_i;
    side_t            sd, sd_i;
    logic [2*S_W+1:0] trial, cur;
    if (g == 0) begin : g_in
      assign rem_i  = '0;
      assign root_i = '0;
      assign val_i  = {{(2*S_W-SQ_W){1'b0}}, in_rad};
      assign sd_i   = in_side;
    end else begin : g_chain
      assign rem_i  = g_st[g-1].rem;
      assign root_i = g_st[g-1].root;
      assign val_i  = g_st[g-1].val;
      assign sd_i   = g_st[g-1].sd;
    end
    always_comb begin
      cur   = {rem_i, val_i[2*S_W-1 -: 2]};
      trial = {{S_W{1'b0}}, root_i, 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem  <= (2*S_W)'(cur - trial);
          root <= {root_i[S_W-2:0], 1'b1};
        end else begin
          rem  <= (2*S_W)'(cur);
          root <= {root_i[S_W-2:0], 1'b0};
        end
        val <= {val_i[2*S_W-3:0], 2'b00};
        sd  <= sd_i;
      end
    end
  end

  assign out_valid = vld[S_W-1];
  assign out_root  = g_st[S_W-1].root;
  assign out_side  = g_st[S_W-1].sd;
endmodule
`default_nettype wire

FILE: rtl/rmq_div_pipe.sv
// Pipelined restoring divider: 2^(2F-1) / s, one quotient bit per stage.
// Depends on rmq_pkg.
`default_nettype none
module rmq_div_pipe import rmq_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [S_W-1:0] in_s,
  input  wire side_t          in_side,
  output logic                out_valid,
  output logic [NUM_W-1:0]    out_inv,
  output logic [S_W-1:0]      out_s,
  output side_t               out_side
);
  logic [NUM_W-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_W-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < NUM_W; g++) begin : g_st
    logic [S_W:0]       rem, rem_i;
    logic [NUM_W-1:0]   quo, quo_i;
    logic [S_W-1:0]     dv, d_i;
    side_t              sd, sd_i;
    logic [S_W+1:0]     cur;
    logic               nbit;
    if (g == 0) begin : g_in
      assign rem_i = '0;
      assign quo_i = '0;
      assign d_i   = in_s;
      assign sd_i  = in_side;
      // dividend has its only set bit at NUM_W-1, i.e. the first stage
      assign nbit  = 1'b1;
    end else begin : g_chain
      assign rem_i = g_st[g-1].rem;
      assign quo_i = g_st[g-1].quo;
      assign d_i   = g_st[g-1].dv;
      assign sd_i  = g_st[g-1].sd;
      assign nbit  = 1'b0;
    end
    assign cur = {rem_i, nbit};
    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= {2'b00, d_i}) begin
          rem <= (S_W+1)'(cur - {2'b00, d_i});
          quo <= {quo_i[NUM_W-2:0], 1'b1};
        end else begin
          rem <= (S_W+1)'(cur);
          quo <= {quo_i[NUM_W-2:0], 1'b0};
        end
        dv <= d_i;
        sd <= sd_i;
      end
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign out_inv   = g_st[NUM_W-1].quo;
  assign out_s     = g_st[NUM_W-1].dv;
  assign out_side  = g_st[NUM_W-1].sd;
endmodule
`default_nettype wire

FILE: verif/rmq_checker.sv
// Checker for the rotation-matrix-to-quaternion core: watches both channels,
// predicts each quaternion from the accepted matrix and compares. Needs rmq_pkg.
`timescale 1ns / 100ps
module rmq_checker import rmq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic mat_valid,
  input  wire logic mat_ready,
  input  wire mat_t mat,
  input  wire logic quat_valid,
  input  wire logic quat_ready,
  input  wire quat_t quat,
  output int        errors,
  output int        pending,
  output int        quats_seen
);

  quat_t quat_queue[$];

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // floor(a*b / 2^F), saturated to 32 bits; operands are small enough for 64-bit product
  function automatic logic signed [31:0] fx_scale(input longint a, input longint b);
    longint p;
    p = (a * b) >>> FRAC_BITS;
    if (p > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (p < -64'sd2147483648) return 32'sh80000000;
    return p[31:0];
  endfunction

  function automatic quat_t predict_quat(input mat_t a);
    longint d[3][3];
    longint one, trace, rad, s, inv;
    logic signed [31:0] q[4];
    int i, j, k;
    quat_t r;
    d[0][0] = a.m00; d[0][1] = a.m01; d[0][2] = a.m02;
    d[1][0] = a.m10; d[1][1] = a.m11; d[1][2] = a.m12;
    d[2][0] = a.m20; d[2][1] = a.m21; d[2][2] = a.m22;
    one = longint'(1) << FRAC_BITS;
    for (int n = 0; n < 4; n++) q[n] = '0;
    r.bad_matrix = 1'b0;
    trace = d[0][0] + d[1][1] + d[2][2];
    if (trace >= 0) begin
      rad = trace + one;
      s = longint'(int_root(longint'(rad) << FRAC_BITS));
      inv = (longint'(1) << (2 * FRAC_BITS - 1)) / s;
      q[3] = s / 2;
      q[0] = fx_scale(d[1][2] - d[2][1], inv);
      q[1] = fx_scale(d[2][0] - d[0][2], inv);
      q[2] = fx_scale(d[0][1] - d[1][0], inv);
    end else begin
      i = 0;
      if (d[1][1] > d[0][0]) i = 1;
      if (d[2][2] > d[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      rad = d[i][i] - (d[j][j] + d[k][k]) + one;
      if (rad <= 0) begin
        r.bad_matrix = 1'b1;
      end else begin
        s = longint'(int_root(longint'(rad) << FRAC_BITS));
        inv = (longint'(1) << (2 * FRAC_BITS - 1)) / s;
        q[i] = s / 2;
        q[3] = fx_scale(d[j][k] - d[k][j], inv);
        q[j] = fx_scale(d[i][j] + d[j][i], inv);
        q[k] = fx_scale(d[i][k] + d[k][i], inv);
      end
    end
    r.quat_x = q[0];
    r.quat_y = q[1];
    r.quat_z = q[2];
    r.quat_w = q[3];
    return r;
  endfunction

  assign pending = quat_queue.size();

  always @(posedge clk) begin
    quat_t want;
    if (rst) begin
      errors <= 0;
      quats_seen <= 0;
    end else begin
      if (mat_valid && mat_ready) quat_queue.push_back(predict_quat(mat));
      if (quat_valid && quat_ready) begin
        quats_seen <= quats_seen + 1;
        if (quat_queue.size() == 0) begin
          $display("%0t: unexpected quaternion beat %h", $time, quat);
          errors <= errors + 1;
        end else begin
          want = quat_queue.pop_front();
          if (want.quat_x !== quat.quat_x || want.quat_y !== quat.quat_y ||
              want.quat_z !== quat.quat_z || want.quat_w !== quat.quat_w ||
              want.bad_matrix !== quat.bad_matrix) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h w=%h bad=%b", $time,
                     want.quat_x, want.quat_y, want.quat_z, want.quat_w, want.bad_matrix);
            $display("%0t:          actual   x=%h y=%h z=%h w=%h bad=%b", $time,
                     quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w, quat.bad_matrix);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for rotation_matrix_to_quaternion_core: clock, reset, matrix stimulus,
// output backpressure and verdict. Needs rmq_pkg, the core and rmq_checker.
`timescale 1ns / 100ps
module tb_top;
  import rmq_pkg::*;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  mat_valid = 1'b0;
  logic  mat_ready;
  mat_t  mat = '0;
  logic  quat_valid;
  logic  quat_ready = 1'b0;
  quat_t quat;
  int    errors, pending, quats_seen;
  int    src_idle = 0;
  int    sink_stall = 0;
  logic  hold_off = 1'b0;
  int    mats_sent = 0;

  localparam logic signed [31:0] ONE  = 32'sd1 << FRAC_BITS;
  localparam logic signed [31:0] SMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  rotation_matrix_to_quaternion_core u_top (
    .clk(clk), .rst(rst), .mat_valid(mat_valid), .mat_ready(mat_ready), .mat(mat),
    .quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat)
  );

  rmq_checker u_chk (
    .clk(clk), .rst(rst), .mat_valid(mat_valid), .mat_ready(mat_ready), .mat(mat),
    .quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat),
    .errors(errors), .pending(pending), .quats_seen(quats_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      quat_ready <= 1'b0;
    end else begin
      quat_ready <= !hold_off && ($urandom_range(99) >= sink_stall);
    end
  end

  task automatic send_mat(input mat_t m);
    while ($urandom_range(99) < src_idle) begin
      mat_valid <= 1'b0;
      @(posedge clk);
    end
    mat <= m;
    mat_valid <= 1'b1;
    @(posedge clk);
    while (!mat_ready) @(posedge clk);
    mats_sent++;
  endtask

  function automatic mat_t diag_mat(input logic signed [31:0] a, b, c);
    mat_t m;
    m = '0;
    m.m00 = a; m.m11 = b; m.m22 = c;
    return m;
  endfunction

  function automatic logic signed [31:0] near_unit();
    return $signed($urandom_range(2 * ONE)) - ONE;
  endfunction

  // Mostly rotation-like entries in [-1,1], some full-range noise for saturation.
  function automatic mat_t rand_mat();
    mat_t m;
    int kind;
    kind = $urandom_range(9);
    if (kind < 6) begin
      m.m00 = near_unit(); m.m01 = near_unit(); m.m02 = near_unit();
      m.m10 = near_unit(); m.m11 = near_unit(); m.m12 = near_unit();
      m.m20 = near_unit(); m.m21 = near_unit(); m.m22 = near_unit();
    end else if (kind < 9) begin
      m = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
    end else begin
      m = '0;
      m.m00 = $urandom_range(1) ? SMAX : SMIN;
      m.m11 = $urandom_range(1) ? SMAX : SMIN;
      m.m22 = $urandom_range(1) ? SMAX : SMIN;
      m.m01 = $urandom; m.m10 = $urandom; m.m12 = $urandom;
      m.m21 = $urandom; m.m02 = $urandom; m.m20 = $urandom;
    end
    return m;
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_mat(rand_mat());
  endtask

  initial begin
    mat_t m;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, zero, each axis dominant on the negative-trace path
    send_mat(diag_mat(ONE, ONE, ONE));
    send_mat('0);
    send_mat(diag_mat(ONE, -ONE, -ONE));
    send_mat(diag_mat(-ONE, ONE, -ONE));
    send_mat(diag_mat(-ONE, -ONE, ONE));
    send_mat(diag_mat(-ONE, -ONE, -ONE));       // tie keeps the lowest axis
    send_mat(diag_mat(0, 0, -ONE));
    send_mat(diag_mat(SMAX, SMAX, SMAX));
    send_mat(diag_mat(SMIN, SMIN, SMIN));
    send_mat(diag_mat(SMAX, SMIN, SMIN));
    send_mat(diag_mat(SMIN, SMAX, SMIN));
    send_mat(diag_mat(SMIN, SMIN, SMAX));
    send_mat(diag_mat(SMAX, SMAX, SMIN));         // trace large and positive
    m = {9{SMAX}};
    send_mat(m);
    m = {9{SMIN}};
    send_mat(m);
    m = diag_mat(0, 0, 0);                      // off-diagonal extremes saturate
    m.m12 = SMAX; m.m21 = SMIN; m.m20 = SMIN; m.m02 = SMAX; m.m01 = SMAX; m.m10 = SMIN;
    send_mat(m);
    m = diag_mat(-ONE, -ONE, -ONE);
    m.m01 = SMAX; m.m10 = SMAX; m.m02 = SMIN; m.m20 = SMIN; m.m12 = SMAX; m.m21 = SMIN;
    send_mat(m);
    m = diag_mat(0, -ONE, -ONE);                // diagonal (0,-1,-1), x dominant on the negative-trace path
    send_mat(m);
    m = '0;                                     // 90 deg about z
    m.m01 = ONE; m.m10 = -ONE; m.m22 = ONE;
    send_mat(m);
    send_mat({9{32'sd1}});
    send_mat({9{-32'sd1}});

    src_idle = 0;  sink_stall = 0;  send_random(500);
    src_idle = 74; sink_stall = 0;  send_random(300);
    src_idle = 0;  sink_stall = 74; send_random(400);
    src_idle = 32; sink_stall = 32; send_random(400);

    // long output hold-off while the input keeps offering beats
    src_idle = 0; sink_stall = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        send_random(280);
        mat_valid <= 1'b0;
      end
    join

    mat_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Sent %0d matrices, checked %0d quaternions over both trace paths,",
             mats_sent, quats_seen);
    $display("saturating entries, input and output idling and a long output hold-off.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d beats outstanding", pending);
    $display("Verification failed");
    $finish;
  end

endmodule
